>>> sv/utf8sd_pkg.sv
`default_nettype none
package utf8sd_pkg;

	typedef logic [20:0] cp_t;
	typedef logic [2:0]  len_t;
	typedef logic [7:0]  byte_t;

	localparam cp_t  REPLACEMENT_CP = 21'h00FFFD;
	localparam int   MAX_RESULTS    = 4;

	localparam byte_t CONT_MASK  = 8'b1100_0000;
	localparam byte_t CONT_TAG   = 8'b1000_0000;
	localparam byte_t LEAD2_MASK = 8'b1110_0000;
	localparam byte_t LEAD2_TAG  = 8'b1100_0000;
	localparam byte_t LEAD3_MASK = 8'b1111_0000;
	localparam byte_t LEAD3_TAG  = 8'b1110_0000;
	localparam byte_t LEAD4_MASK = 8'b1111_1000;
	localparam byte_t LEAD4_TAG  = 8'b1111_0000;
	localparam byte_t CONT_BITS  = 8'b0011_1111;
	localparam byte_t LEAD2_BITS = 8'b0001_1111;
	localparam byte_t LEAD3_BITS = 8'b0000_1111;
	localparam byte_t LEAD4_BITS = 8'b0000_0111;

	localparam len_t LEN_NONE = 3'd0;
	localparam len_t LEN_ONE  = 3'd1;
	localparam len_t LEN_TWO  = 3'd2;
	localparam len_t LEN_THREE = 3'd3;
	localparam len_t LEN_FOUR = 3'd4;

endpackage
`default_nettype wire

>>> sv/utf8sd_byte_if.sv
`default_nettype none
interface utf8sd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface
`default_nettype wire

>>> sv/utf8sd_cp_if.sv
`default_nettype none
interface utf8sd_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        run_last;
	logic        string_last;

	modport source (output valid, output code_point, output run_last, output string_last,
		input ready);
	modport sink (input valid, input code_point, input run_last, input string_last,
		output ready);
endinterface
`default_nettype wire

>>> sv/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: takes one byte per transaction on byte_in and gives one
// 21-bit codepoint per sequence on cp_out, with U+FFFD for each invalid or truncated
// position (lead byte and each buffered continuation byte); overlong forms and
// surrogates pass through. Each byte is held in the input register and decoded as
// it moves into the result register, so with one result per byte and cp_out ready
// the block sustains one byte per cycle. A byte that breaks or truncates a sequence
// gives up to four results, which leave the result register one per cycle while
// cp_out is ready; the next byte waits in the input register. Lead bytes of
// multi-byte sequences give no result unless they carry end_of_input (last
// byte of a string); string_last flags its final codepoint and the decoder goes idle.
`default_nettype none
module utf8_stream_decoder_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	utf8sd_byte_if.sink    byte_in,
	utf8sd_cp_if.source    cp_out
);
	import utf8sd_pkg::*;

	// input register
	logic  valid_s1;
	byte_t byte_s1;
	logic  eoi_s1;

	// decoder state
	len_t exp_q;
	len_t cnt_q;
	cp_t  pv_q;

	// result register: remaining results, last value, end flag
	len_t rem_q;
	cp_t  last_q;
	logic eoi_q;

	logic move;
	logic out_fire;

	assign out_fire = cp_out.valid && cp_out.ready;
	assign move     = valid_s1 && (rem_q == LEN_NONE || (rem_q == LEN_ONE && cp_out.ready));
	assign byte_in.ready = !valid_s1 || move;

	// decode of the byte in the input register
	logic  is_cont;
	logic  is_ascii;
	logic  is_lead;
	len_t  lead_len;
	cp_t   lead_val;
	len_t  begin_n;
	cp_t   begin_last;
	cp_t   acc;
	len_t  cnt_inc;
	len_t  n_d;
	cp_t   last_d;
	len_t  exp_d;
	len_t  cnt_d;
	cp_t   pv_d;

	always_comb begin
		is_cont  = (byte_s1 & CONT_MASK) == CONT_TAG;
		is_ascii = !byte_s1[7];
		is_lead  = 1'b1;
		lead_len = LEN_NONE;
		lead_val = '0;
		if ((byte_s1 & LEAD2_MASK) == LEAD2_TAG) begin
			lead_len = LEN_TWO;
			lead_val = cp_t'(byte_s1 & LEAD2_BITS);
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_TAG) begin
			lead_len = LEN_THREE;
			lead_val = cp_t'(byte_s1 & LEAD3_BITS);
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_TAG) begin
			lead_len = LEN_FOUR;
			lead_val = cp_t'(byte_s1 & LEAD4_BITS);
		end else begin
			is_lead = 1'b0;
		end

		// fresh start: a pending lead emits nothing unless the string ends here
		begin_n    = (is_lead && !eoi_s1) ? LEN_NONE : LEN_ONE;
		begin_last = is_ascii ? cp_t'(byte_s1) : REPLACEMENT_CP;

		acc     = {pv_q[14:0], byte_s1[5:0]};
		cnt_inc = 3'(cnt_q + LEN_ONE);

		n_d    = begin_n;
		last_d = begin_last;
		exp_d  = (is_lead && !eoi_s1) ? lead_len : LEN_NONE;
		cnt_d  = (is_lead && !eoi_s1) ? LEN_ONE : LEN_NONE;
		pv_d   = (is_lead && !eoi_s1) ? lead_val : '0;

		if (exp_q != LEN_NONE) begin
			if (is_cont) begin
				exp_d = LEN_NONE;
				cnt_d = LEN_NONE;
				pv_d  = '0;
				if (cnt_inc >= exp_q) begin
					n_d    = LEN_ONE;
					last_d = acc;
				end else if (eoi_s1) begin
					// truncated: one replacement per byte taken
					n_d    = cnt_inc;
					last_d = REPLACEMENT_CP;
				end else begin
					n_d    = LEN_NONE;
					last_d = REPLACEMENT_CP;
					exp_d  = exp_q;
					cnt_d  = cnt_inc;
					pv_d   = acc;
				end
			end else begin
				// broken: flush the buffered bytes, then decode this one afresh
				n_d    = 3'(cnt_q + begin_n);
				last_d = (begin_n != LEN_NONE) ? begin_last : REPLACEMENT_CP;
			end
		end

		if (eoi_s1) begin
			exp_d = LEN_NONE;
			cnt_d = LEN_NONE;
			pv_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
			eoi_s1  <= byte_in.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= LEN_NONE;
			cnt_q <= LEN_NONE;
			pv_q  <= '0;
			rem_q <= LEN_NONE;
		end else if (move) begin
			exp_q <= exp_d;
			cnt_q <= cnt_d;
			pv_q  <= pv_d;
			rem_q <= n_d;
		end else if (out_fire) begin
			rem_q <= 3'(rem_q - LEN_ONE);
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			last_q <= last_d;
			eoi_q  <= eoi_s1;
		end
	end

	assign cp_out.valid       = rem_q != LEN_NONE;
	assign cp_out.run_last    = rem_q == LEN_ONE;
	assign cp_out.string_last = (rem_q == LEN_ONE) && eoi_q;
	assign cp_out.code_point  = (rem_q == LEN_ONE) ? last_q : REPLACEMENT_CP;

	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'(MAX_RESULTS))
		else $error("result count exceeds the per-byte maximum");

	a_pending_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(exp_q == LEN_NONE) ? (cnt_q == LEN_NONE)
			: (cnt_q >= LEN_ONE && cnt_q < exp_q))
		else $error("pending sequence count out of range");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		move && eoi_s1 |=> exp_q == LEN_NONE && cnt_q == LEN_NONE)
		else $error("pending state survives end of string");

	a_early_fffd: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !cp_out.run_last |-> cp_out.code_point == REPLACEMENT_CP)
		else $error("non-final result is not a replacement");

	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> valid_s1 && $stable(byte_s1) && $stable(eoi_s1))
		else $error("input register lost a byte while the result register was busy");

endmodule
`default_nettype wire
